[rtl/core/lzw_variable_width_decoder_assert.svh]
// assertion macros for the lzw variable width decoder
// used by lzw_variable_width_decoder.sv, no other dependencies
`ifndef LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define LZW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzw decoder: same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define LZW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzw decoder: next-cycle check failed");

`endif

[rtl/core/lzwvwd_pkg.sv]
// shared types and constants of the lzw variable width decoder
// no dependencies
`timescale 1ns / 1ps

package lzwvwd_pkg;

   // port widths
   localparam int CODE_W  = 9;
   localparam int DATA_W  = 64;
   localparam int COUNT_W = 4;
   localparam int WIDTH_W = 4;
   localparam int CFG_W   = 4;

   // code counter width
   localparam int CTR_W = 13;

   // fixed codes and dictionary restart values
   localparam int unsigned END_CODE        = 256;
   localparam int unsigned FIRST_FREE      = 257;
   localparam int unsigned START_WIDTH     = 9;
   localparam int unsigned START_THRESHOLD = 512;
   localparam int unsigned RESTART_SPAN    = 4096;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_UPDATE,
      ST_HEAD,
      ST_POP,
      ST_TAIL,
      ST_ENDM
   } lzwvwd_state_type;

endpackage

[rtl/core/lzw_variable_width_decoder.sv]
// lzw variable width decoder top level: dictionary, chain walk, byte packer
// depends on lzwvwd_pkg and lzw_variable_width_decoder_assert.svh
`timescale 1ns / 1ps
`include "lzw_variable_width_decoder_assert.svh"

//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------------
//  req      | in        | req_valid/req_ready  | req_code
//  rsp      | out       | rsp_valid/rsp_ready  | rsp_data_bytes, rsp_byte_count,
//           |           |                      | rsp_last_of_run, rsp_end_of_stream,
//           |           |                      | rsp_next_code_width
//  csr      | in        | csr_valid/csr_ready  | csr_max_code_bits (always ready)
//
// a dictionary code with a chain of L entries is first accepted, then its prefix chain is walked
// with one table read per cycle, then the dictionary is updated, and then the decoded bytes come
// out of the reverse string stack
// a first code skips the walk and the update, the end marker goes through its own end state
// synchronous active-high reset, no clearing pass: the tables are undefined until written
// the byte packer stalls only while a finished result waits and the next group is complete

module lzw_variable_width_decoder #(
   parameter int MAX_CODE_BITS    = 9,
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lzwvwd_pkg::CODE_W-1:0] req_code,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lzwvwd_pkg::DATA_W-1:0] rsp_data_bytes,
   output logic [lzwvwd_pkg::COUNT_W-1:0] rsp_byte_count,
   output logic                          rsp_last_of_run,
   output logic                          rsp_end_of_stream,
   output logic [lzwvwd_pkg::WIDTH_W-1:0] rsp_next_code_width,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lzwvwd_pkg::CFG_W-1:0]  csr_max_code_bits
);
   import lzwvwd_pkg::*;

   // table and stack geometry
   localparam int CW          = MAX_CODE_BITS;
   localparam int TABLE_SIZE  = 1 << MAX_CODE_BITS;
   localparam int STACK_DEPTH = 64 * BYTES_PER_RESULT;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int PACK_W      = 8 * BYTES_PER_RESULT;
   localparam int SLOT_W      = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

   localparam logic [SP_W-1:0]    WALK_LIMIT = SP_W'(STACK_DEPTH - 2);
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(BYTES_PER_RESULT - 1);
   localparam logic [CW-1:0]      END_CW     = CW'(END_CODE);
   localparam logic [3:0]         MAX_BITS_4 = 4'(MAX_CODE_BITS);
   localparam logic [3:0]         START_W_4  = 4'(START_WIDTH);

   // storage
   logic [CW-1:0] prefix_mem [TABLE_SIZE];
   logic [7:0]    suffix_mem [TABLE_SIZE];
   logic [7:0]    stack_mem  [STACK_DEPTH];

   // state registers
   lzwvwd_state_type     state_ff, state_in;
   logic [CFG_W-1:0]     cfg_bits_ff;
   logic [CTR_W-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]        prev_ff, prev_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic [CTR_W-1:0]     thr_ff, thr_in;
   logic                 expect_ff, expect_in;

   // per-item registers
   logic [CW-1:0]        code_ff, code_in;
   logic                 undef_ff, undef_in;
   logic [7:0]           first_ff, first_in;
   logic [SP_W-1:0]      depth_ff, depth_in;
   logic [SP_W-1:0]      sp_ff, sp_in;

   // memory read data
   logic [CW-1:0]        rd_prefix_ff;
   logic [7:0]           rd_suffix_ff;
   logic [7:0]           stack_rd_ff;

   // packer and output register
   logic [PACK_W-1:0]    pack_word_ff;
   logic [SLOT_W-1:0]    pack_cnt_ff;
   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_data_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_last_ff;
   logic                 rsp_eos_ff;
   logic [WIDTH_W-1:0]   rsp_width_ff;

   // sequencer outputs
   logic                 mem_rd_en;
   logic [CW-1:0]        mem_rd_addr;
   logic                 mem_we;
   logic                 stk_we;
   logic                 stk_re;
   logic [SP_W-1:0]      stk_rd_addr;
   logic                 push_en;
   logic [7:0]           push_byte;
   logic                 push_last;
   logic                 end_load;

   // datapath helpers
   logic [CW-1:0]        code_ext;
   logic [3:0]           bits_use;
   logic [13:0]          limit;
   logic [13:0]          restart_at;
   logic [CTR_W-1:0]     cnt_inc;
   logic                 table_room;
   logic                 grow;
   logic                 restart;
   logic                 undef_now;
   logic [CW-1:0]        walk0;
   logic [SP_W-1:0]      depth_inc;
   logic                 out_free;
   logic                 completes;
   logic                 push_done;
   logic [PACK_W-1:0]    merged_word;

   assign csr_ready = 1'b1;
   assign code_ext  = CW'(req_code);

   // usable width limit, clamped to the supported range
   always_comb begin
      if (cfg_bits_ff < START_W_4) begin
         bits_use = START_W_4;
      end else if (cfg_bits_ff > MAX_BITS_4) begin
         bits_use = MAX_BITS_4;
      end else begin
         bits_use = cfg_bits_ff;
      end
   end

   assign limit      = 14'd1 << bits_use;
   assign restart_at = limit + 14'(RESTART_SPAN);
   assign cnt_inc    = cnt_ff + 13'd1;
   assign table_room = {1'b0, cnt_ff} < limit;
   assign grow       = table_room && (width_ff < bits_use) && (cnt_ff == thr_ff - 13'd1);
   assign restart    = {1'b0, cnt_inc} == restart_at;

   // code not yet defined: expand the previous code instead
   assign undef_now  = CTR_W'(code_ext) >= cnt_ff;
   assign walk0      = undef_now ? prev_ff : code_ext;
   assign depth_inc  = depth_ff + SP_W'(1);

   // byte packer: a push that closes a group needs the output register free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign completes = (pack_cnt_ff == LAST_SLOT) || push_last;
   assign push_done = push_en && (!completes || out_free);

   always_comb begin
      merged_word = pack_word_ff;
      merged_word[{pack_cnt_ff, 3'b000} +: 8] = push_byte;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      prev_in     = prev_ff;
      width_in    = width_ff;
      thr_in      = thr_ff;
      expect_in   = expect_ff;
      code_in     = code_ff;
      undef_in    = undef_ff;
      first_in    = first_ff;
      depth_in    = depth_ff;
      sp_in       = sp_ff;
      req_ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = walk0;
      mem_we      = 1'b0;
      stk_we      = 1'b0;
      stk_re      = 1'b0;
      stk_rd_addr = depth_ff - SP_W'(1);
      push_en     = 1'b0;
      push_byte   = first_ff;
      push_last   = 1'b0;
      end_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (code_ext == END_CW) begin
                  // end marker: restart counters, table contents stay
                  cnt_in    = CTR_W'(FIRST_FREE);
                  width_in  = WIDTH_W'(START_WIDTH);
                  thr_in    = CTR_W'(START_THRESHOLD);
                  expect_in = 1'b1;
                  state_in  = ST_ENDM;
               end else if (expect_ff) begin
                  // first code after a restart goes out as a literal
                  first_in  = code_ext[7:0];
                  prev_in   = code_ext;
                  expect_in = 1'b0;
                  depth_in  = '0;
                  undef_in  = 1'b0;
                  state_in  = ST_HEAD;
               end else begin
                  code_in  = code_ext;
                  undef_in = undef_now;
                  depth_in = '0;
                  if (walk0 > END_CW) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = walk0;
                     state_in    = ST_WALK;
                  end else begin
                     first_in = walk0[7:0];
                     state_in = ST_UPDATE;
                  end
               end
            end
         end
         ST_WALK: begin
            // read data belongs to the current chain entry
            stk_we   = 1'b1;
            depth_in = depth_inc;
            if ((rd_prefix_ff > END_CW) && (depth_inc < WALK_LIMIT)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_prefix_ff;
            end else begin
               first_in = rd_prefix_ff[7:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (table_room) begin
               mem_we = 1'b1;
            end
            if (grow) begin
               width_in = width_ff + WIDTH_W'(1);
               thr_in   = thr_ff << 1;
            end
            prev_in = code_ff;
            if (restart) begin
               cnt_in    = CTR_W'(FIRST_FREE);
               width_in  = WIDTH_W'(START_WIDTH);
               thr_in    = CTR_W'(START_THRESHOLD);
               expect_in = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
            // prefetch the newest stack byte
            if (depth_ff != '0) begin
               stk_re      = 1'b1;
               stk_rd_addr = depth_ff - SP_W'(1);
               sp_in       = depth_ff - SP_W'(1);
            end
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            push_en   = 1'b1;
            push_byte = first_ff;
            push_last = (depth_ff == '0) && !undef_ff;
            if (push_done) begin
               if (depth_ff != '0) begin
                  state_in = ST_POP;
               end else if (undef_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POP: begin
            push_en   = 1'b1;
            push_byte = stack_rd_ff;
            push_last = (sp_ff == '0) && !undef_ff;
            if (push_done) begin
               if (sp_ff != '0) begin
                  stk_re      = 1'b1;
                  stk_rd_addr = sp_ff - SP_W'(1);
                  sp_in       = sp_ff - SP_W'(1);
               end else if (undef_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            // undefined code ends with its own first byte
            push_en   = 1'b1;
            push_byte = first_ff;
            push_last = 1'b1;
            if (push_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_ENDM: begin
            if (out_free) begin
               end_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cfg_bits_ff <= CFG_W'(START_WIDTH);
         cnt_ff      <= CTR_W'(FIRST_FREE);
         prev_ff     <= '0;
         width_ff    <= WIDTH_W'(START_WIDTH);
         thr_ff      <= CTR_W'(START_THRESHOLD);
         expect_ff   <= 1'b1;
         depth_ff    <= '0;
         sp_ff       <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         prev_ff   <= prev_in;
         width_ff  <= width_in;
         thr_ff    <= thr_in;
         expect_ff <= expect_in;
         depth_ff  <= depth_in;
         sp_ff     <= sp_in;
         if (csr_valid && csr_ready) begin
            cfg_bits_ff <= csr_max_code_bits;
         end
      end
   end

   // per-item payload registers
   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      undef_ff <= undef_in;
      first_ff <= first_in;
   end

   // dictionary tables: one read and one write port
   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_prefix_ff <= prefix_mem[mem_rd_addr];
         rd_suffix_ff <= suffix_mem[mem_rd_addr];
      end
      if (mem_we) begin
         prefix_mem[cnt_ff[CW-1:0]] <= prev_ff;
         suffix_mem[cnt_ff[CW-1:0]] <= first_ff;
      end
   end

   // reverse string stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[depth_ff] <= rd_suffix_ff;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem[stk_rd_addr];
      end
   end

   // byte packer, cleared after each group so unused slots read zero
   always_ff @(posedge clock) begin
      if (reset) begin
         pack_word_ff <= '0;
         pack_cnt_ff  <= '0;
      end else if (push_done) begin
         if (completes) begin
            pack_word_ff <= '0;
            pack_cnt_ff  <= '0;
         end else begin
            pack_word_ff <= merged_word;
            pack_cnt_ff  <= pack_cnt_ff + SLOT_W'(1);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((push_done && completes) || end_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_load) begin
         rsp_data_ff  <= '0;
         rsp_count_ff <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_eos_ff   <= 1'b1;
         rsp_width_ff <= width_ff;
      end else if (push_done && completes) begin
         rsp_data_ff  <= DATA_W'(merged_word);
         rsp_count_ff <= COUNT_W'(pack_cnt_ff) + COUNT_W'(1);
         rsp_last_ff  <= push_last;
         rsp_eos_ff   <= 1'b0;
         rsp_width_ff <= width_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data_bytes      = rsp_data_ff;
   assign rsp_byte_count      = rsp_count_ff;
   assign rsp_last_of_run     = rsp_last_ff;
   assign rsp_end_of_stream   = rsp_eos_ff;
   assign rsp_next_code_width = rsp_width_ff;

   // end marker result carries no bytes and closes its run
   `LZW_ASSERT_IMPL(a_eos_shape, clock, reset, rsp_valid_ff && rsp_eos_ff, (rsp_count_ff == '0) && rsp_last_ff)

   // data results carry one to a full group of bytes
   `LZW_ASSERT_IMPL(a_data_count, clock, reset, rsp_valid_ff && !rsp_eos_ff, (rsp_count_ff != '0) && (rsp_count_ff <= COUNT_W'(BYTES_PER_RESULT)))

   // code width stays within the supported range
   `LZW_ASSERT_IMPL(a_width_range, clock, reset, 1'b1, (width_ff >= START_W_4) && (width_ff <= MAX_BITS_4))

   // an accepted end marker restarts the dictionary counters
   `LZW_ASSERT_NEXT(a_end_restart, clock, reset, (state_ff == ST_IDLE) && req_valid && (code_ext == END_CW), (cnt_ff == CTR_W'(FIRST_FREE)) && expect_ff && (width_ff == START_W_4))

endmodule

[test/lzw_variable_width_decoder_tb.sv]
// self-checking testbench of the lzw variable width decoder: directed rows, then random code streams
// predicts every result item with a dictionary model of its own
// depends on lzwvwd_pkg and lzw_variable_width_decoder
`timescale 1ns / 1ps

module lzw_variable_width_decoder_tb;
   import lzwvwd_pkg::*;

   // block configuration under test
   localparam int TABLE_BITS  = 9;
   localparam int GROUP_BYTES = 8;
   localparam int TABLE_SIZE  = 1 << TABLE_BITS;
   localparam int STACK_DEPTH = 64 * GROUP_BYTES;
   localparam int WALK_CAP    = STACK_DEPTH - 2;
   localparam int COUNT_MASK  = (1 << CTR_W) - 1;
   localparam int MAX_SHOWN   = 10;

   // one decoded result item, in port order
   typedef struct packed {
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      logic               last;
      logic               eos;
      logic [WIDTH_W-1:0] width;
   } rsp_item_type;

   // one directed row: code, and where typed, the single result it must give
   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic               typed;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
   } directed_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CODE_W-1:0]   req_code;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [DATA_W-1:0]   rsp_data_bytes;
   logic [COUNT_W-1:0]  rsp_byte_count;
   logic                rsp_last_of_run;
   logic                rsp_end_of_stream;
   logic [WIDTH_W-1:0]  rsp_next_code_width;
   logic                csr_valid;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_max_code_bits;

   lzw_variable_width_decoder #(
      .MAX_CODE_BITS    (TABLE_BITS),
      .BYTES_PER_RESULT (GROUP_BYTES)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_code            (req_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_bytes      (rsp_data_bytes),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_end_of_stream   (rsp_end_of_stream),
      .rsp_next_code_width (rsp_next_code_width),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_code_bits   (csr_max_code_bits)
   );

   // ------------------------------------------------------------------
   // dictionary model kept by the testbench
   // ------------------------------------------------------------------
   logic [CODE_W-1:0] dict_prefix  [TABLE_SIZE];
   logic [7:0]        dict_suffix  [TABLE_SIZE];
   bit                dict_written [TABLE_SIZE];
   int unsigned       free_code;
   int unsigned       prior_code;
   int unsigned       code_width;
   int unsigned       grow_at;
   bit                stream_fresh;
   logic [CFG_W-1:0]  width_cap;

   // result items still owed by the block, oldest first
   rsp_item_type pending_rsps [$];

   int fail_count;
   int calm_cycles;

   // back to the start of a stream, table contents are kept
   function automatic void restart_dictionary();
      free_code    = FIRST_FREE;
      code_width   = START_WIDTH;
      grow_at      = START_THRESHOLD;
      stream_fresh = 1'b1;
   endfunction

   // decode one code into the model, queue its result items when keep is set
   task automatic decode_code(input logic [CODE_W-1:0] raw_code, input bit keep);
      logic [7:0]  walk_stack [STACK_DEPTH];
      logic [7:0]  out_bytes  [STACK_DEPTH];
      int unsigned code_val, counter, bits, limit, walk, depth, n, groups, pos;
      bit          undefined;
      logic [7:0]  head_byte;
      rsp_item_type item;
      code_val = raw_code & (TABLE_SIZE - 1);
      n = 0;
      if (code_val == END_CODE) begin
         restart_dictionary();
         item = '{'0, '0, 1'b1, 1'b1, WIDTH_W'(code_width)};
         if (keep) pending_rsps.push_back(item);
         return;
      end
      if (stream_fresh) begin
         // first code of a stream goes out as its low byte, even above 255
         out_bytes[n++] = code_val[7:0];
         prior_code = code_val;
         stream_fresh = 1'b0;
      end else begin
         counter = free_code;
         bits = (width_cap < START_WIDTH) ? START_WIDTH :
                (width_cap > TABLE_BITS) ? TABLE_BITS : width_cap;
         limit = 1 << bits;
         // code not yet in the table: previous string plus its own first byte
         undefined = code_val >= counter;
         walk = undefined ? prior_code : code_val;
         depth = 0;
         while (walk > END_CODE && depth < WALK_CAP) begin
            walk_stack[depth++] = dict_suffix[walk];
            walk = dict_prefix[walk];
         end
         head_byte = walk[7:0];
         out_bytes[n++] = head_byte;
         while (depth > 0) out_bytes[n++] = walk_stack[--depth];
         if (undefined) out_bytes[n++] = head_byte;
         if (counter < limit) begin
            dict_prefix[counter]  = CODE_W'(prior_code);
            dict_suffix[counter]  = head_byte;
            dict_written[counter] = 1'b1;
            if (code_width < bits && counter == grow_at - 1) begin
               code_width++;
               grow_at = grow_at << 1;
            end
         end
         prior_code = code_val;
         counter = (counter + 1) & COUNT_MASK;
         // table full: counter runs on until the restart point
         if (counter == limit + RESTART_SPAN) begin
            restart_dictionary();
         end else begin
            free_code = counter;
         end
      end
      groups = (n + GROUP_BYTES - 1) / GROUP_BYTES;
      for (int g = 0; g < groups; g++) begin
         item = '0;
         for (int i = 0; i < GROUP_BYTES; i++) begin
            pos = g * GROUP_BYTES + i;
            if (pos < n) begin
               item.data[8*i +: 8] = out_bytes[pos];
               item.count++;
            end
         end
         item.last  = (g == groups - 1);
         item.width = WIDTH_W'(code_width);
         if (keep) pending_rsps.push_back(item);
      end
   endtask

   // a chain walk from here only reads entries that were written
   function automatic bit chain_safe(input int unsigned start);
      int unsigned walk, steps;
      walk = start;
      steps = 0;
      while (walk > END_CODE && steps < WALK_CAP) begin
         if (!dict_written[walk]) return 1'b0;
         walk = dict_prefix[walk];
         steps++;
      end
      return 1'b1;
   endfunction

   function automatic bit code_is_safe(input logic [CODE_W-1:0] c);
      if (c == END_CODE || stream_fresh) return 1'b1;
      if (c >= free_code) return chain_safe(prior_code);
      return chain_safe(c);
   endfunction

   // short gaps mostly, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // mostly well-formed codes: literals and table codes up to the free code,
   // some end markers and some noise; long runs keep the stream open
   function automatic logic [CODE_W-1:0] pick_code(input bit long_run);
      int r, top;
      logic [CODE_W-1:0] c;
      top = (free_code >= TABLE_SIZE) ? TABLE_SIZE - 1 : free_code;
      for (int tries = 0; tries < 20; tries++) begin
         r = $urandom_range(0, 99);
         if (long_run)
            c = (r < 75) ? CODE_W'($urandom_range(0, 255)) :
                           CODE_W'($urandom_range(FIRST_FREE, top));
         else if (r < 8)
            c = CODE_W'(END_CODE);
         else if (r < 40)
            c = CODE_W'($urandom_range(0, 255));
         else if (r < 90)
            c = CODE_W'($urandom_range(FIRST_FREE, top));
         else
            c = CODE_W'($urandom_range(0, TABLE_SIZE - 1));
         if (code_is_safe(c)) return c;
      end
      return CODE_W'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // channel drivers, all inputs change at the falling edge
   // ------------------------------------------------------------------

   // present one input item and hold it until accepted
   task automatic send_code(input logic [CODE_W-1:0] c);
      int gap;
      gap = (calm_cycles > 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code  <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // write the width cap once every owed result has come back
   task automatic write_width_cap(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_max_code_bits <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      width_cap = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // directed rows: typed where the answer is plain, otherwise the model decides
   directed_row_type directed_rows [21] = '{
      '{CODE_W'(END_CODE), 1'b1, 64'h0,  4'd0},   // end marker while a first code is due
      '{9'd0,              1'b1, 64'h00, 4'd1},   // smallest first code
      '{9'd255,            1'b1, 64'hff, 4'd1},   // largest literal
      '{9'd257,            1'b0, 64'h0,  4'd0},   // two-byte string
      '{9'd259,            1'b0, 64'h0,  4'd0},   // code equal to the free code
      '{CODE_W'(END_CODE), 1'b1, 64'h0,  4'd0},
      '{9'd511,            1'b1, 64'hff, 4'd1},   // first code above 255, low byte only
      '{9'd65,             1'b1, 64'h41, 4'd1},
      '{CODE_W'(END_CODE), 1'b1, 64'h0,  4'd0},
      '{9'd65,             1'b1, 64'h41, 4'd1},
      '{9'd258,            1'b0, 64'h0,  4'd0},   // past the free code: entry 258 left open
      '{9'd66,             1'b1, 64'h42, 4'd1},   // entry 258 now points at itself
      '{9'd258,            1'b0, 64'h0,  4'd0},   // cyclic chain, walk cut short
      '{9'd300,            1'b0, 64'h0,  4'd0},   // cyclic chain plus head byte, most results
      '{CODE_W'(END_CODE), 1'b1, 64'h0,  4'd0},
      '{9'd72,             1'b1, 64'h48, 4'd1},
      '{9'd73,             1'b1, 64'h49, 4'd1},
      '{9'd257,            1'b0, 64'h0,  4'd0},
      '{9'd259,            1'b0, 64'h0,  4'd0},
      '{9'd259,            1'b0, 64'h0,  4'd0},
      '{CODE_W'(END_CODE), 1'b1, 64'h0,  4'd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side stalls, with calm stretches where neither side idles
   initial begin : rsp_backpressure
      int hold;
      hold = 0;
      rsp_ready = 1'b1;
      calm_cycles = 0;
      forever begin
         @(negedge clock);
         if (calm_cycles > 0) calm_cycles--;
         else if ($urandom_range(0, 99) == 0) calm_cycles = $urandom_range(40, 150);
         if (calm_cycles > 0) begin
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // compare every accepted result item with the oldest one owed
   always @(posedge clock) begin : rsp_checker
      rsp_item_type seen, want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_data_bytes, rsp_byte_count, rsp_last_of_run,
                  rsp_end_of_stream, rsp_next_code_width};
         if (pending_rsps.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("unexpected result item: data %h count %0d last %b eos %b width %0d",
                        seen.data, seen.count, seen.last, seen.eos, seen.width);
         end else begin
            want = pending_rsps.pop_front();
            if (seen !== want) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("result mismatch: expected data %h count %0d last %b eos %b width %0d, got data %h count %0d last %b eos %b width %0d",
                           want.data, want.count, want.last, want.eos, want.width,
                           seen.data, seen.count, seen.last, seen.eos, seen.width);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [CODE_W-1:0] c;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_code          = '0;
      csr_valid         = 1'b0;
      csr_max_code_bits = '0;
      fail_count        = 0;
      foreach (dict_written[i]) begin
         dict_written[i] = 1'b0;
         dict_prefix[i]  = '0;
         dict_suffix[i]  = '0;
      end
      prior_code = 0;
      width_cap  = CFG_W'(START_WIDTH);
      restart_dictionary();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset width cap
      foreach (directed_rows[i]) begin
         if (directed_rows[i].typed)
            pending_rsps.push_back('{directed_rows[i].data, directed_rows[i].count, 1'b1,
                                     directed_rows[i].code == END_CODE,
                                     WIDTH_W'(START_WIDTH)});
         decode_code(directed_rows[i].code, !directed_rows[i].typed);
         send_code(directed_rows[i].code);
      end

      // random streams at the cap extremes, all clamp to the table size
      write_width_cap(4'd15);
      repeat (30) begin
         c = pick_code(1'b0);
         decode_code(c, 1'b1);
         send_code(c);
      end

      write_width_cap(4'd0);
      repeat (30) begin
         c = pick_code(1'b0);
         decode_code(c, 1'b1);
         send_code(c);
      end

      // one open stream long enough to fill the table and run past it
      write_width_cap(4'd12);
      c = CODE_W'(END_CODE);
      decode_code(c, 1'b1);
      send_code(c);
      repeat (262) begin
         c = pick_code(1'b1);
         decode_code(c, 1'b1);
         send_code(c);
      end

      write_width_cap(4'd9);
      repeat (10) begin
         c = pick_code(1'b0);
         decode_code(c, 1'b1);
         send_code(c);
      end

      // drain, then let the block settle
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_rsps.size() == 0) begin
         $display("lzw_variable_width_decoder verification clean");
      end else begin
         $display("lzw_variable_width_decoder verification failed");
      end
      $finish;
   end

   // hang guard, far past the slowest legal run
   initial begin : watchdog
      #40_000_000;
      $display("lzw_variable_width_decoder verification failed");
      $finish;
   end

endmodule
